>>> hw/rtl/sem_pkg.sv
package sem_pkg;

  // Field and register widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FW_W       = 13;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned ROW_W      = 17;
  localparam int unsigned GRAD_W     = 10;
  localparam int unsigned SUM_W      = 21;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Root input range: sums at or above 2**ROOT_IN_W clamp to EDGE_MAX
  localparam int unsigned ROOT_IN_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 16'd480;
  localparam logic [PIX_W-1:0] EDGE_MAX         = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;

  // Request and response of the root unit
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
  } root_req_t;

  typedef struct packed {
    logic done;
    pix_t value;
  } root_rsp_t;

endpackage

>>> hw/rtl/sem_isqrt.sv
module sem_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sem_pkg::root_req_t  req_i,
  output sem_pkg::root_rsp_t  rsp_o
);

  localparam int unsigned RW = sem_pkg::ROOT_IN_W + 1;

  logic [RW-1:0]       rem_q;
  logic [RW-1:0]       root_q;
  logic [1:0]          cnt_q;
  logic                busy_q;
  logic                done_q;
  sem_pkg::pix_t       value_q;

  logic [4:0]          shift_a;
  logic [RW-1:0]       bit_a;
  logic [RW-1:0]       bit_b;
  logic [2*RW-1:0]     step1;
  logic [2*RW-1:0]     step2;

  // One digit of the restoring square root: returns {remainder, root}
  function automatic logic [2*RW-1:0] root_step(input logic [RW-1:0] rem,
                                                input logic [RW-1:0] root,
                                                input logic [RW-1:0] bitv);
    logic [RW-1:0] trial;
    begin
      trial = root + bitv;
      if (rem >= trial) begin
        root_step = {rem - trial, (root >> 1) + bitv};
      end else begin
        root_step = {rem, root >> 1};
      end
    end
  endfunction

  // Two digits per cycle, bit weights 4**7 down to 4**0
  assign shift_a = 5'd14 - {1'b0, cnt_q, 2'b00};
  assign bit_a   = RW'(1) << shift_a;
  assign bit_b   = bit_a >> 2;
  assign step1   = root_step(rem_q, root_q, bit_a);
  assign step2   = root_step(step1[2*RW-1:RW], step1[RW-1:0], bit_b);

  // Clamp large sums at once, otherwise iterate down to the last digit pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        if (req_i.sum[sem_pkg::SUM_W-1:sem_pkg::ROOT_IN_W] != '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold remainder, partial root and result
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {1'b0, req_i.sum[sem_pkg::ROOT_IN_W-1:0]};
      root_q <= '0;
      if (req_i.sum[sem_pkg::SUM_W-1:sem_pkg::ROOT_IN_W] != '0) begin
        value_q <= sem_pkg::EDGE_MAX;
      end
    end else if (busy_q) begin
      rem_q  <= step2[2*RW-1:RW];
      root_q <= step2[RW-1:0];
      if (cnt_q == 2'd3) begin
        value_q <= step2[sem_pkg::PIX_W-1:0];
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;

endmodule

>>> hw/rtl/sobel_edge_magnitude_core.sv
// An accepted item passes the line update (ST_UPD); one that yields a word then goes through
// ST_SQR and ST_ROOT (ST_SEND while the output is held) into the output register. A new item
// is taken only in ST_IDLE, so each item is through before the next is accepted; the pace
// is set by the line memory read-modify-write and the 2-digit-per-cycle square root unit;
// a word held by m_axis_tready adds its wait cycles. Reset (async, active low) clears window,
// counters and output valid, loads 640x480; the line memory is not cleared, needs no pass.
module sobel_edge_magnitude_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] pixel
  input  logic                             s_axis_tuser,   // [0] kind (1 = flush)
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // [7:0] edge_value
  output logic                             m_axis_tlast,   // frame_end
  input  logic                             cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW  = ((WW > sem_pkg::FW_W) ? WW : sem_pkg::FW_W) + 1;
  localparam int unsigned PW  = sem_pkg::PIX_W;
  localparam int unsigned GW  = sem_pkg::GRAD_W;
  localparam int unsigned RW  = sem_pkg::ROW_W;
  localparam int unsigned HW  = sem_pkg::FH_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SQR,
    ST_ROOT,
    ST_SEND
  } state_e;

  state_e                    state_q;
  logic                      m_valid_q;
  sem_pkg::pix_t             m_data_q;
  logic                      m_last_q;

  logic [sem_pkg::FW_W-1:0]  frame_width_q;
  logic [HW-1:0]             frame_height_q;

  logic [2*PW-1:0]           line_mem [MAX_WIDTH];
  logic [2*PW-1:0]           mem_rd_q;

  sem_pkg::pix_t             win_q   [3][3];
  sem_pkg::pix_t             win_new [3][3];
  sem_pkg::pix_t             tap     [3][3];
  logic [CW-1:0]             in_col_q;
  logic [RW-1:0]             in_row_q;
  logic [CW-1:0]             out_col_q;
  logic [HW-1:0]             out_row_q;

  sem_pkg::pix_t             data_q;
  logic [GW-1:0]             ax_q;
  logic [GW-1:0]             ay_q;
  logic                      last_q;

  logic [XW-1:0]             fw_x;
  logic [XW-1:0]             w_eff;
  logic [RW-1:0]             h_eff;
  logic                      in_accept;
  logic                      out_free;
  logic                      emit;
  logic                      last;
  logic [XW-1:0]             in_col_p1;
  logic [XW-1:0]             cx;
  logic [RW-1:0]             rx;
  logic [2:0]                rv;
  logic [2:0]                cv;
  logic [GW-1:0]             gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GW-1:0]             ax, ay;
  logic [2*GW-1:0]           sq_x, sq_y;
  sem_pkg::root_req_t        root_req;
  sem_pkg::root_rsp_t        root_rsp;

  // Effective frame size
  assign fw_x  = XW'(frame_width_q);
  assign w_eff = (fw_x == '0) ? XW'(1) :
                 (fw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : fw_x;
  assign h_eff = (frame_height_q == '0) ? RW'(1) : RW'(frame_height_q);

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sem_pkg::FRAME_WIDTH_RST;
      frame_height_q <= sem_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (sem_pkg::cfg_reg_e'(cfg_idx_i))
        sem_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[sem_pkg::FW_W-1:0];
        sem_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // Line memory: entry holds {row two above, row above}; read on accept, write back in update
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      line_mem[in_col_q] <= {mem_rd_q[PW-1:0], data_q};
    end
    if (in_accept) begin
      mem_rd_q <= line_mem[in_col_q];
    end
  end

  // Shift the window and insert the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_new[i][0] = win_q[i][1];
      win_new[i][1] = win_q[i][2];
    end
    win_new[0][2] = mem_rd_q[2*PW-1:PW];
    win_new[1][2] = mem_rd_q[PW-1:0];
    win_new[2][2] = data_q;
  end

  // Position bookkeeping
  assign emit      = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  assign in_col_p1 = XW'(in_col_q) + XW'(1);
  assign cx        = XW'(out_col_q);
  assign rx        = RW'(out_row_q);
  assign last      = ((rx + RW'(1)) >= h_eff) && ((cx + XW'(1)) >= w_eff);

  // Mask taps outside the frame
  assign rv[0] = (rx != '0) && (rx <= h_eff);
  assign rv[1] = (rx < h_eff);
  assign rv[2] = ((rx + RW'(1)) < h_eff);
  assign cv[0] = (cx != '0) && (cx <= w_eff);
  assign cv[1] = (cx < w_eff);
  assign cv[2] = ((cx + XW'(1)) < w_eff);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap[i][j] = (rv[i] && cv[j]) ? win_new[i][j] : '0;
      end
    end
  end

  // Sobel gradients as magnitude of positive minus negative half
  assign gx_pos = GW'(tap[2][0]) + {1'b0, tap[2][1], 1'b0} + GW'(tap[2][2]);
  assign gx_neg = GW'(tap[0][0]) + {1'b0, tap[0][1], 1'b0} + GW'(tap[0][2]);
  assign gy_pos = GW'(tap[0][2]) + {1'b0, tap[1][2], 1'b0} + GW'(tap[2][2]);
  assign gy_neg = GW'(tap[0][0]) + {1'b0, tap[1][0], 1'b0} + GW'(tap[2][0]);
  assign ax     = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
  assign ay     = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);

  // Window and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (state_q == ST_UPD) begin
      if (emit && last) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_q[i][j] <= '0;
          end
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        win_q <= win_new;
        if (in_col_p1 >= w_eff) begin
          in_col_q <= '0;
          if (in_row_q != '1) begin
            in_row_q <= in_row_q + RW'(1);
          end
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
        if (emit) begin
          if ((cx + XW'(1)) >= w_eff) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HW'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
    end
  end

  // Capture input pixel, gradients and frame end flag
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= (!s_axis_tuser && (in_row_q < h_eff)) ? s_axis_tdata : '0;
    end
    if (state_q == ST_UPD) begin
      ax_q   <= ax;
      ay_q   <= ay;
      last_q <= last;
    end
  end

  // Sum of squares into the root unit
  assign sq_x           = {{GW{1'b0}}, ax_q} * {{GW{1'b0}}, ax_q};
  assign sq_y           = {{GW{1'b0}}, ay_q} * {{GW{1'b0}}, ay_q};
  assign root_req.start = (state_q == ST_SQR);
  assign root_req.sum   = sem_pkg::SUM_W'(sq_x) + sem_pkg::SUM_W'(sq_y);

  sem_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  // Sequencer and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_q <= emit ? ST_SQR : ST_IDLE;
        end
        ST_SQR: begin
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_rsp.done) begin
            if (out_free) begin
              m_valid_q <= 1'b1;
              m_data_q  <= root_rsp.value;
              m_last_q  <= last_q;
              state_q   <= ST_IDLE;
            end else begin
              state_q <= ST_SEND;
            end
          end
        end
        ST_SEND: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= root_rsp.value;
            m_last_q  <= last_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // The root unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_rsp.done |-> (state_q == ST_ROOT))
    else $error("root result outside of root wait");

  // Line memory read data is consumed in the cycle after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_UPD))
    else $error("accepted word not followed by line update");

  // Input column stays inside the line memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(in_col_q) < XW'(MAX_WIDTH))
    else $error("input column beyond line memory");

  // A frame end result leaves all positions at the frame origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && emit && last |=>
      (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
    else $error("positions not cleared at frame end");

endmodule

>>> tb/sv/sobel_tb_pkg.sv
package sobel_tb_pkg;
  import sem_pkg::*;

  // Line store depth, must match the MAX_WIDTH of the instance
  localparam int unsigned LINE_MAX = 4096;

  typedef struct packed {
    pix_t magnitude;
    logic frame_end;
  } mag_word_t;

  // Edge predictor and the queue of magnitudes it has promised
  class edge_scoreboard;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    pix_t            line_mem [2*LINE_MAX];
    pix_t            win [3][3];
    int unsigned     in_col, in_row, out_col, out_row;
    mag_word_t       mag_q [$];
    int unsigned     n_mags, n_clamped, n_frames, n_fail;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (line_mem[i]) line_mem[i] = '0;
      restart_frame();
      n_mags    = 0;
      n_clamped = 0;
      n_frames  = 0;
      n_fail    = 0;
    endfunction

    function void restart_frame();
      foreach (win[i, j]) win[i][j] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = val[FW_W-1:0];
        REG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return mag_q.size();
    endfunction

    function bit mid_frame();
      return (in_col | in_row | out_col | out_row) != 0;
    endfunction

    // Advance the window by one accepted word and queue the magnitude it releases
    function void note_word(logic flush, pix_t pix);
      int unsigned w, h, col, r, c, sum, root, trial;
      pix_t        data, top, mid;
      bit          emit, last;
      bit [2:0]    rv, cv;
      int          p [3][3];
      int          gx, gy;
      mag_word_t   word;

      // zero means one, oversize widths stop at the line store depth
      w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      col = (in_col >= LINE_MAX) ? 0 : in_col;
      // flush words and words past the last row carry zero
      data = (!flush && in_row < h) ? pix : '0;

      top = line_mem[LINE_MAX + col];
      mid = line_mem[col];
      line_mem[LINE_MAX + col] = mid;
      line_mem[col] = data;

      // shift left, new column enters on the right
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = data;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row < 'h1FFFF) in_row++;
      end else begin
        in_col++;
      end
      if (!emit) return;

      // mask taps that fall outside the frame
      r  = out_row;
      c  = out_col;
      rv = {r + 1 < h, r < h, r >= 1 && r <= h};
      cv = {c + 1 < w, c < w, c >= 1 && c <= w};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i][j] = (rv[i] && cv[j]) ? int'(win[i][j]) : 0;

      gx  = p[2][0] + 2 * p[2][1] + p[2][2] - p[0][0] - 2 * p[0][1] - p[0][2];
      gy  = p[0][2] + 2 * p[1][2] + p[2][2] - p[0][0] - 2 * p[1][0] - p[2][0];
      sum = gx * gx + gy * gy;

      if (sum >= 65536) begin
        root = EDGE_MAX;
        n_clamped++;
      end else begin
        // build the floor root one bit at a time from the top
        root = 0;
        for (int b = 7; b >= 0; b--) begin
          trial = root | (1 << b);
          if (trial * trial <= sum) root = trial;
        end
      end

      last = (r + 1 >= h) && (c + 1 >= w);
      word.magnitude = pix_t'(root);
      word.frame_end = last;
      mag_q.push_back(word);

      if (last) begin
        restart_frame();
      end else if (c + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    // Compare one received word against the oldest promised magnitude
    function void check_word(pix_t mag, logic fend);
      mag_word_t want;

      if (mag_q.size() == 0) begin
        $error("magnitude %0d (frame_end %0b) arrived with nothing expected", mag, fend);
        n_fail++;
        return;
      end
      want = mag_q.pop_front();
      n_mags++;
      if (want.frame_end) n_frames++;
      if (mag !== want.magnitude) begin
        $error("edge_value: expected %0d, got %0d", want.magnitude, mag);
        n_fail++;
      end
      if (fend !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, fend);
        n_fail++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_sobel_edge_magnitude_core.sv
module tb_sobel_edge_magnitude_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sem_pkg::*;
  import sobel_tb_pkg::*;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;    // [7:0] pixel
  logic                    s_axis_tuser  = 1'b0;  // [0] kind (1 = flush)
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;          // [7:0] edge_value
  logic                    m_axis_tlast;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;

  edge_scoreboard sb;
  int unsigned    n_words;
  int unsigned    src_calm;
  int unsigned    snk_calm;

  always #5 clk_i = ~clk_i;

  sobel_edge_magnitude_core #(
    .MAX_WIDTH(LINE_MAX)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Random wait before the next word, with occasional runs of no waiting
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(8, 64);
    return $urandom_range(0, 7);
  endfunction

  // Pixel content: uniform noise, hard black/white, or a flat field with spikes
  function automatic pix_t pick_pixel(int unsigned style);
    case (style)
      0: return pix_t'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return ($urandom_range(0, 7) == 0) ? pix_t'($urandom) : 8'd96;
    endcase
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic send_word(logic flush, pix_t pix);
    int unsigned gap;
    gap = draw_wait(src_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= flush;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_word(flush, pix);
    n_words++;
  endtask

  // Pixels with the odd flush word inside, then drain words of either kind
  task automatic send_frame(int unsigned n_pix, int unsigned n_drain);
    int unsigned style;
    style = $urandom_range(0, 2);
    for (int unsigned i = 0; i < n_pix; i++)
      send_word($urandom_range(0, 23) == 0, pick_pixel(style));
    for (int unsigned i = 0; i < n_drain; i++)
      send_word(1'($urandom_range(0, 1)), pix_t'($urandom));
  endtask

  // Hold the input until every promised magnitude is out and the pipe is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write width, then height, back to back
  task automatic set_frame(logic [CFG_DATA_W-1:0] wv, logic [CFG_DATA_W-1:0] hv);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FRAME_WIDTH;
    cfg_data_i <= wv;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FRAME_HEIGHT;
    cfg_data_i <= hv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(REG_FRAME_WIDTH, wv);
    sb.set_reg(REG_FRAME_HEIGHT, hv);
  endtask

  // Feed drain words until the current frame wraps up
  task automatic close_frame();
    while (sb.mid_frame()) send_word(1'($urandom_range(0, 1)), pix_t'($urandom));
  endtask

  initial begin : stimulus
    int unsigned           w, h, n_pix, n_drain, start;
    logic [CFG_DATA_W-1:0] wv, hv;

    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3: dark row over bright rows saturates, a flush word inside the frame,
    // and pixel words after the last row that must be ignored
    set_frame(16'd3, 16'd3);
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd255);
    send_word(1'b0, 8'd255);
    send_word(1'b0, 8'd255);
    send_word(1'b0, 8'd255);
    send_word(1'b1, 8'd255);
    send_word(1'b0, 8'd255);
    send_word(1'b1, 8'd0);
    send_word(1'b0, 8'hA5);
    send_word(1'b1, 8'h33);
    send_word(1'b0, 8'hFF);
    settle();

    // zero width and zero height act as a single pixel
    set_frame(16'd0, 16'd0);
    send_word(1'b0, 8'h5A);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'hFF);
    settle();

    // 2x2 with mid-range values, some of them past the clamp
    set_frame(16'd2, 16'd2);
    send_word(1'b0, 8'd10);
    send_word(1'b0, 8'd200);
    send_word(1'b0, 8'd37);
    send_word(1'b0, 8'd0);
    send_word(1'b1, 8'd0);
    send_word(1'b0, 8'd77);
    send_word(1'b1, 8'd1);
    settle();

    // Single row 128 wide; this writes both line store rows for every column used later
    set_frame(16'd128, 16'd1);
    send_frame(128, 129);
    settle();

    // Oversize width and tallest height, then shrink both mid-frame
    set_frame(16'hFFFF, 16'hFFFF);
    send_frame(20, 0);
    settle();
    set_frame(16'd5, 16'd4);
    close_frame();
    settle();

    // One pixel wide and tall, then cut the height below the rows already seen
    set_frame(16'd1, 16'hFFFF);
    send_frame(30, 0);
    settle();
    set_frame(16'd1, 16'd3);
    close_frame();
    settle();

    // Random frames, mostly well formed, some cut short or overrun
    w = 1;
    h = 3;
    start = n_words;
    while (n_words - start < 800) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 11) == 0) begin
          w = $urandom_range(13, 96);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 9);
        end
        wv = (w == 1 && $urandom_range(0, 3) == 0) ? 16'd0 : 16'(w);
        hv = (h == 1 && $urandom_range(0, 3) == 0) ? 16'd0 : 16'(h);
        settle();
        set_frame(wv, hv);
      end
      n_pix   = w * h;
      n_drain = w + 1;
      case ($urandom_range(0, 9))
        0: begin
          n_pix   = $urandom_range(1, w * h);
          n_drain = 0;
        end
        1: n_drain = $urandom_range(0, w);
        2: n_drain = w + 1 + $urandom_range(1, w + 1);
        default: ;
      endcase
      send_frame(n_pix, n_drain);
    end
    close_frame();

    // Drain what is left, bounded
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && sb.pending() != 0; i++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected magnitudes never arrived", sb.pending());
      sb.n_fail++;
    end

    $display("Fed %0d words, checked %0d magnitudes over %0d frames, %0d of them clamped.",
             n_words, sb.n_mags, sb.n_frames, sb.n_clamped);
    $display("Widths 1 to %0d, heights 1 to 65535, resizes mid-frame, stalls on both sides.",
             LINE_MAX);
    if (sb.n_fail == 0) begin
      $display("tb_sobel_edge_magnitude_core: PASS");
    end else begin
      $display("tb_sobel_edge_magnitude_core: FAIL");
    end
    $finish;
  end

  // Output side: random stalls, then take and check one word
  initial begin : sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(snk_calm);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_word(m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog
  initial begin : watchdog
    #(30_000_000);
    $display("tb_sobel_edge_magnitude_core: FAIL");
    $finish;
  end

endmodule
